// ===== src/irpd_pkg.sv =====
// Shared types, widths and timing windows of the IR pulse-distance decoder.
package irpd_pkg;

	localparam int FRAME_BITS = 24;
	localparam int FIELD_W    = 6;
	localparam int CNT_W      = $clog2(FRAME_BITS + 1);
	localparam int DUR_W      = 16;
	localparam int TIME_W     = 32;
	localparam int CODE_W     = 14;
	localparam int SPEED_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Inclusive duration windows, microseconds
	localparam logic [DUR_W-1:0] HDR_PULSE_MIN  = 16'd2000;
	localparam logic [DUR_W-1:0] HDR_PULSE_MAX  = 16'd3000;
	localparam logic [DUR_W-1:0] HDR_SPACE_MIN  = 16'd2000;
	localparam logic [DUR_W-1:0] HDR_SPACE_MAX  = 16'd3000;
	localparam logic [DUR_W-1:0] BIT_PULSE_MIN  = 16'd300;
	localparam logic [DUR_W-1:0] BIT_PULSE_MAX  = 16'd700;
	localparam logic [DUR_W-1:0] ONE_SPACE_MIN  = 16'd1300;
	localparam logic [DUR_W-1:0] ONE_SPACE_MAX  = 16'd1900;
	localparam logic [DUR_W-1:0] ZERO_SPACE_MIN = 16'd300;
	localparam logic [DUR_W-1:0] ZERO_SPACE_MAX = 16'd700;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HSPACE = 2'd1,
		PH_BPULSE = 2'd2,
		PH_BSPACE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_KEY    = 2'd1,
		ST_ERROR  = 2'd2,
		ST_REPEAT = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE  = 3'd0,
		CFG_HEAD    = 3'd1,
		CFG_RSPEED  = 3'd2,
		CFG_DSPEED  = 3'd3,
		CFG_TIMEOUT = 3'd4
	} cfg_idx_t;

endpackage

// ===== src/irpd_ifs.sv =====
// Request channels of the IR pulse-distance decoder: events, results, register writes.
interface irpd_in_if import irpd_pkg::*;;
	logic              valid;
	logic              ready;
	logic              is_pulse;
	logic [DUR_W-1:0]  duration;
	logic [TIME_W-1:0] now_time;

	modport source (output valid, is_pulse, duration, now_time, input ready);
	modport sink   (input valid, is_pulse, duration, now_time, output ready);
endinterface

interface irpd_out_if import irpd_pkg::*;;
	logic               valid;
	logic               ready;
	status_t            status;
	logic [FIELD_W-1:0] custom_high;
	logic [FIELD_W-1:0] custom_low;
	logic [FIELD_W-1:0] key_code;
	logic               repeat_mark;

	modport source (output valid, status, custom_high, custom_low, key_code, repeat_mark,
		input ready);
	modport sink   (input valid, status, custom_high, custom_low, key_code, repeat_mark,
		output ready);
endinterface

interface irpd_cfg_if import irpd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ir_pulse_distance_decoder_core.sv =====
// Top level of the IR pulse-distance decoder: event register, decode logic, result register.
//
// Decodes a 24-bit pulse-distance IR frame from a stream of mark/space events. Each request on
// item carries one mark or space with its length in microseconds and a 32-bit wrapping
// timestamp; every request gives exactly one result request on result. A frame is a header
// mark, a header space, then 24 bit marks each followed by a space whose length gives the bit,
// LSB first. The frame splits into custom_low, key, custom_high and inverted key (6 bits each);
// it is reported (status 1) when the custom code matches head_code and the key checks against
// its inverse. Repeats of the same frame inside repeat_timeout are swallowed (status 3) until
// the repeat limit is reached, then reported with repeat_mark set. A wrong event kind or length
// gives status 2 and drops back to waiting for a header; while protocol_enable is clear every
// event gives status 2 and leaves the decoder untouched. Throughput is one event per clock
// while the result side keeps taking results: the event is registered, the decode and all
// state updates happen in the single compare-and-shift stage that follows, and the result
// register takes the answer. The result register decouples the two sides; a stalled result
// holds the pipe only when both stages are full. Register writes are taken at any time on
// cfg (ready is always high) but must only be issued while no event is in flight.
module ir_pulse_distance_decoder_core import irpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	irpd_in_if.sink   item,
	irpd_out_if.source result,
	irpd_cfg_if.sink  cfg
);

	// Configuration registers
	logic               enable_q;
	logic [CODE_W-1:0]  head_code_q;
	logic [SPEED_W-1:0] remote_speed_q;
	logic [SPEED_W-1:0] default_speed_q;
	logic [DUR_W-1:0]   timeout_q;

	// Decoder state
	phase_t                phase_q, phase_d;
	logic [CNT_W-1:0]      bit_count_q, bit_count_d;
	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic [FRAME_BITS-1:0] prev_frame_q, prev_frame_d;
	logic [TIME_W-1:0]     last_time_q, last_time_d;
	logic [SPEED_W-1:0]    rep_count_q, rep_count_d;
	logic                  latched_q, latched_d;

	// Event stage
	logic              vld_s1;
	logic              is_pulse_s1;
	logic [DUR_W-1:0]  duration_s1;
	logic [TIME_W-1:0] now_time_s1;

	// Result stage
	logic               vld_s2;
	status_t            status_s2;
	logic [FIELD_W-1:0] chi_s2, clo_s2, key_s2;
	logic               rep_s2;

	// Decode outputs
	status_t            st;
	logic [FIELD_W-1:0] chi, clo, key;
	logic               rep;
	logic               ok;

	// Decode helpers
	logic                  res_free, adv_s1;
	logic                  hdr_pulse_win, hdr_space_win, bit_pulse_win, one_win, zero_win;
	logic [FRAME_BITS-1:0] shifted;
	logic [CNT_W-1:0]      bit_count_inc;
	logic [FIELD_W-1:0]    f_clo, f_key, f_chi, f_inv;
	logic                  code_ok;
	logic [TIME_W-1:0]     gap;
	logic                  in_time, same_frame, repeat_hit, limit_hit;

	// Handshakes: advance the event stage whenever the result register is free or draining
	assign res_free   = !vld_s2 || result.ready;
	assign adv_s1     = vld_s1 && res_free;
	assign item.ready = !vld_s1 || res_free;
	assign cfg.ready  = 1'b1;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			head_code_q     <= '0;
			remote_speed_q  <= '0;
			default_speed_q <= '0;
			timeout_q       <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_ENABLE:  enable_q        <= cfg.data[0];
				CFG_HEAD:    head_code_q     <= cfg.data[CODE_W-1:0];
				CFG_RSPEED:  remote_speed_q  <= cfg.data[SPEED_W-1:0];
				CFG_DSPEED:  default_speed_q <= cfg.data[SPEED_W-1:0];
				CFG_TIMEOUT: timeout_q       <= cfg.data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	// Event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			is_pulse_s1 <= item.is_pulse;
			duration_s1 <= item.duration;
			now_time_s1 <= item.now_time;
		end
	end

	// Duration windows
	assign hdr_pulse_win = duration_s1 >= HDR_PULSE_MIN && duration_s1 <= HDR_PULSE_MAX;
	assign hdr_space_win = duration_s1 >= HDR_SPACE_MIN && duration_s1 <= HDR_SPACE_MAX;
	assign bit_pulse_win = duration_s1 >= BIT_PULSE_MIN && duration_s1 <= BIT_PULSE_MAX;
	assign one_win       = duration_s1 >= ONE_SPACE_MIN && duration_s1 <= ONE_SPACE_MAX;
	assign zero_win      = duration_s1 >= ZERO_SPACE_MIN && duration_s1 <= ZERO_SPACE_MAX;

	// New bit enters at the top, so the first bit ends in bit 0
	assign shifted       = {one_win, shift_q[FRAME_BITS-1:1]};
	assign bit_count_inc = bit_count_q + CNT_W'(1);

	assign f_clo = shifted[FIELD_W-1:0];
	assign f_key = shifted[2*FIELD_W-1:FIELD_W];
	assign f_chi = shifted[3*FIELD_W-1:2*FIELD_W];
	assign f_inv = shifted[4*FIELD_W-1:3*FIELD_W];

	// Custom code is third field shifted by 8 ORed with the first; bits 7:6 must be zero
	assign code_ok = ({f_chi, 2'b00, f_clo} == head_code_q) && (f_key == ~f_inv);

	// Gap is modulo 2^32 so a wrapped timestamp still compares
	assign gap        = now_time_s1 - last_time_q;
	assign in_time    = gap <= {{(TIME_W-DUR_W){1'b0}}, timeout_q};
	assign same_frame = prev_frame_q == shifted;
	assign repeat_hit = in_time && same_frame;
	assign limit_hit  = (latched_q && remote_speed_q != '0) ?
		(rep_count_q >= remote_speed_q - SPEED_W'(1)) : (rep_count_q >= default_speed_q);

	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		prev_frame_d = prev_frame_q;
		last_time_d  = last_time_q;
		rep_count_d  = rep_count_q;
		latched_d    = latched_q;
		st           = ST_ERROR;
		chi          = '0;
		clo          = '0;
		key          = '0;
		rep          = 1'b0;
		ok           = 1'b0;
		if (enable_q) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (is_pulse_s1 && hdr_pulse_win) begin
						bit_count_d = '0;
						phase_d     = PH_HSPACE;
						ok          = 1'b1;
					end
				end
				PH_HSPACE: begin
					if (!is_pulse_s1 && hdr_space_win) begin
						phase_d = PH_BPULSE;
						ok      = 1'b1;
					end
				end
				PH_BPULSE: begin
					if (is_pulse_s1 && bit_pulse_win) begin
						phase_d = PH_BSPACE;
						ok      = 1'b1;
					end
				end
				PH_BSPACE: begin
					if (!is_pulse_s1) begin
						// A bad space still leaves the register shifted
						shift_d = shifted;
						if (one_win || zero_win) begin
							bit_count_d = bit_count_inc;
							ok          = 1'b1;
							if (bit_count_inc != CNT_W'(FRAME_BITS)) begin
								phase_d = PH_BPULSE;
							end else if (!code_ok) begin
								phase_d     = PH_IDLE;
								bit_count_d = '0;
							end else if (repeat_hit && !limit_hit) begin
								// Swallow the repeat
								rep_count_d = rep_count_q + SPEED_W'(1);
								last_time_d = now_time_s1;
								phase_d     = PH_IDLE;
								shift_d     = '0;
								bit_count_d = '0;
								st          = ST_REPEAT;
							end else begin
								prev_frame_d = shifted;
								chi          = f_chi;
								clo          = f_clo;
								key          = f_key;
								rep          = repeat_hit;
								latched_d    = 1'b1;
								last_time_d  = now_time_s1;
								phase_d      = PH_IDLE;
								shift_d      = '0;
								bit_count_d  = '0;
								if (!repeat_hit) begin
									rep_count_d = '0;
								end
								st = ST_KEY;
							end
						end
					end
				end
				default: ;
			endcase
			if (!ok) begin
				phase_d = PH_IDLE;
				st      = ST_ERROR;
			end else if (st == ST_ERROR) begin
				st = ST_NONE;
			end
		end
	end

	// State advances only with the event that drives it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			shift_q      <= '0;
			prev_frame_q <= '0;
			last_time_q  <= '0;
			rep_count_q  <= '0;
			latched_q    <= 1'b0;
		end else if (adv_s1) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			prev_frame_q <= prev_frame_d;
			last_time_q  <= last_time_d;
			rep_count_q  <= rep_count_d;
			latched_q    <= latched_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (res_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= st;
			chi_s2    <= chi;
			clo_s2    <= clo;
			key_s2    <= key;
			rep_s2    <= rep;
		end
	end

	assign result.valid       = vld_s2;
	assign result.status      = status_s2;
	assign result.custom_high = chi_s2;
	assign result.custom_low  = clo_s2;
	assign result.key_code    = key_s2;
	assign result.repeat_mark = rep_s2;

	// Checks
	a_bitcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q < CNT_W'(FRAME_BITS))
		else $error("bit count reached frame length without leaving the bit phase");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && status_s2 != ST_KEY) |->
		(chi_s2 == '0 && clo_s2 == '0 && key_s2 == '0 && !rep_s2))
		else $error("frame fields set on a result without a key");

	a_event_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> vld_s2)
		else $error("advanced event produced no result");

	a_repeat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && st == ST_REPEAT) |=> rep_count_q == $past(rep_count_q) + SPEED_W'(1))
		else $error("swallowed repeat did not advance the repeat count");

	a_key_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (st == ST_KEY || st == ST_REPEAT)) |=>
		(phase_q == PH_IDLE && shift_q == '0 && bit_count_q == '0))
		else $error("frame state not cleared after a complete frame");

endmodule

// ===== dv/tb_ir_pulse_distance_decoder_core.sv =====
// Self-checking testbench for the IR pulse-distance decoder core.
`timescale 1ns / 100ps

module tb_ir_pulse_distance_decoder_core;
	import irpd_pkg::*;

	// One mark or space as offered on the event channel
	typedef struct packed {
		logic              is_pulse;
		logic [DUR_W-1:0]  duration;
		logic [TIME_W-1:0] now_time;
	} ir_event_t;

	// One decoder report as it leaves on the result channel
	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] custom_high;
		logic [FIELD_W-1:0] custom_low;
		logic [FIELD_W-1:0] key_code;
		logic               repeat_mark;
	} ir_report_t;

	logic clk;
	logic arst_n;

	irpd_in_if  ev_bus ();
	irpd_out_if rpt_bus ();
	irpd_cfg_if cfg_bus ();

	ir_pulse_distance_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (ev_bus),
		.result (rpt_bus),
		.cfg    (cfg_bus)
	);

	// Marks and spaces still waiting to be offered, and reports still owed by the block
	ir_event_t  ir_events[$];
	ir_report_t owed_reports[$];

	// Register copy kept in step with every write request that lands
	logic                reg_enable;
	logic [CODE_W-1:0]   reg_head;
	logic [SPEED_W-1:0]  reg_rspeed;
	logic [SPEED_W-1:0]  reg_dspeed;
	logic [DUR_W-1:0]    reg_timeout;

	// Decoder state as the block should hold it
	phase_t              dec_phase;
	logic [CNT_W-1:0]    dec_bits;
	logic [FRAME_BITS-1:0] dec_shift;
	logic [FRAME_BITS-1:0] dec_prev_frame;
	logic [TIME_W-1:0]   dec_last_key;
	logic [SPEED_W-1:0]  dec_repeats;
	logic                dec_latched;

	// Stimulus bookkeeping
	logic [TIME_W-1:0] t_now;
	int                phase_events;
	int                fail_count;
	logic              calm;       // no idling on either side once set
	int                src_gap;
	int                sink_gap;
	int                hold_req;   // bumped by the stimulus to ask for one long receiver stall
	int                hold_seen;
	int                hold_left;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall time limit: far beyond the slowest legal run
	initial begin
		#(4_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic in_win(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
		logic [DUR_W-1:0] hi);
		return d >= lo && d <= hi;
	endfunction

	// Time since the last reported or swallowed key, modulo the counter width
	function automatic logic [TIME_W-1:0] t_gap(logic [TIME_W-1:0] now);
		return now - dec_last_key;
	endfunction

	// Advance the decoder copy by one mark or space and return the report it owes.
	function automatic ir_report_t decode_event(ir_event_t ev);
		ir_report_t       rpt;
		logic             taken;
		logic             hit;
		logic [FIELD_W-1:0] inv_key, c_high, key, c_low;

		rpt = '0;
		rpt.status = ST_NONE;
		taken = 1'b0;

		// Disabled: everything is an error and nothing moves
		if (!reg_enable) begin
			rpt.status = ST_ERROR;
			return rpt;
		end

		case (dec_phase)
		PH_IDLE: begin
			if (ev.is_pulse && in_win(ev.duration, HDR_PULSE_MIN, HDR_PULSE_MAX)) begin
				dec_bits = '0;
				dec_phase = PH_HSPACE;
				taken = 1'b1;
			end
		end
		PH_HSPACE: begin
			if (!ev.is_pulse && in_win(ev.duration, HDR_SPACE_MIN, HDR_SPACE_MAX)) begin
				dec_phase = PH_BPULSE;
				taken = 1'b1;
			end
		end
		PH_BPULSE: begin
			if (ev.is_pulse && in_win(ev.duration, BIT_PULSE_MIN, BIT_PULSE_MAX)) begin
				dec_phase = PH_BSPACE;
				taken = 1'b1;
			end
		end
		PH_BSPACE: begin
			if (!ev.is_pulse) begin
				// The shift happens even when the space turns out to be bad
				dec_shift = dec_shift >> 1;
				if (in_win(ev.duration, ONE_SPACE_MIN, ONE_SPACE_MAX)) begin
					dec_shift[FRAME_BITS-1] = 1'b1;
					taken = 1'b1;
				end else if (in_win(ev.duration, ZERO_SPACE_MIN, ZERO_SPACE_MAX)) begin
					taken = 1'b1;
				end
			end
			if (taken) begin
				dec_bits = dec_bits + 1'b1;
				if (dec_bits != CNT_W'(FRAME_BITS)) begin
					dec_phase = PH_BPULSE;
				end else begin
					inv_key = dec_shift[23:18];
					c_high  = dec_shift[17:12];
					key     = dec_shift[11:6];
					c_low   = dec_shift[5:0];
					if ({c_high, 8'(c_low)} != reg_head || key != ~inv_key) begin
						// Foreign remote or corrupt key: back to idle, shift kept
						dec_phase = PH_IDLE;
						dec_bits = '0;
					end else begin
						hit = 1'b1;
						if (TIME_W'(t_gap(ev.now_time)) <= TIME_W'(reg_timeout) &&
							dec_prev_frame == dec_shift) begin
							if (dec_latched && reg_rspeed != 0)
								hit = dec_repeats >= reg_rspeed - 1'b1;
							else
								hit = dec_repeats >= reg_dspeed;
							rpt.repeat_mark = hit;
						end
						if (!hit) begin
							// Held key still under its limit: swallow it
							dec_repeats = dec_repeats + 1'b1;
							dec_last_key = ev.now_time;
							dec_phase = PH_IDLE;
							dec_shift = '0;
							dec_bits = '0;
							rpt.status = ST_REPEAT;
						end else begin
							dec_prev_frame = dec_shift;
							rpt.custom_high = c_high;
							rpt.custom_low  = c_low;
							rpt.key_code    = key;
							dec_latched = 1'b1;
							dec_last_key = ev.now_time;
							dec_phase = PH_IDLE;
							dec_shift = '0;
							dec_bits = '0;
							if (!rpt.repeat_mark)
								dec_repeats = '0;
							rpt.status = ST_KEY;
						end
					end
				end
			end
		end
		endcase

		if (!taken) begin
			dec_phase = PH_IDLE;
			rpt = '0;
			rpt.status = ST_ERROR;
		end
		return rpt;
	endfunction

	// Sender: pop pending events, hold each until accepted, and book the owed report.
	always @(posedge clk) begin
		ir_event_t nxt;
		if (!arst_n) begin
			ev_bus.valid <= 1'b0;
		end else begin
			if (ev_bus.valid && ev_bus.ready) begin
				nxt.is_pulse = ev_bus.is_pulse;
				nxt.duration = ev_bus.duration;
				nxt.now_time = ev_bus.now_time;
				owed_reports.push_back(decode_event(nxt));
			end
			if (ev_bus.valid && !ev_bus.ready) begin
				// hold the request until the block takes it
			end else if (src_gap > 0) begin
				src_gap--;
				ev_bus.valid <= 1'b0;
			end else if (ir_events.size() > 0) begin
				nxt = ir_events.pop_front();
				ev_bus.is_pulse <= nxt.is_pulse;
				ev_bus.duration <= nxt.duration;
				ev_bus.now_time <= nxt.now_time;
				ev_bus.valid    <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 4);
			end else begin
				ev_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver: check each report against the oldest owed one, stall at random.
	always @(posedge clk) begin
		ir_report_t want, seen;
		if (!arst_n) begin
			rpt_bus.ready <= 1'b0;
		end else begin
			if (rpt_bus.valid && rpt_bus.ready) begin
				seen.status      = rpt_bus.status;
				seen.custom_high = rpt_bus.custom_high;
				seen.custom_low  = rpt_bus.custom_low;
				seen.key_code    = rpt_bus.key_code;
				seen.repeat_mark = rpt_bus.repeat_mark;
				if (owed_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: report with none owed: st=%0d chi=%0d clo=%0d key=%0d rep=%0d",
							$realtime, seen.status, seen.custom_high, seen.custom_low,
							seen.key_code, seen.repeat_mark);
				end else begin
					want = owed_reports.pop_front();
					if (seen.status !== want.status || seen.custom_high !== want.custom_high ||
						seen.custom_low !== want.custom_low || seen.key_code !== want.key_code ||
						seen.repeat_mark !== want.repeat_mark) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("%0t: report mismatch: want st=%0d chi=%0d clo=%0d key=%0d rep=%0d",
								$realtime, want.status, want.custom_high, want.custom_low,
								want.key_code, want.repeat_mark);
							$display(" got st=%0d chi=%0d clo=%0d key=%0d rep=%0d",
								seen.status, seen.custom_high, seen.custom_low,
								seen.key_code, seen.repeat_mark);
						end
					end
				end
			end
			if (hold_req != hold_seen) begin
				// long stall: lets both stages fill so the event side backs up
				hold_seen = hold_req;
				hold_left = 60;
				rpt_bus.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rpt_bus.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rpt_bus.ready <= 1'b0;
			end else begin
				rpt_bus.ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					sink_gap = $urandom_range(1, 4);
			end
		end
	end

	task automatic queue_event(logic p, logic [DUR_W-1:0] d);
		ir_event_t ev;
		ev.is_pulse = p;
		ev.duration = d;
		ev.now_time = t_now;
		ir_events.push_back(ev);
		t_now += $urandom_range(0, 3);
		phase_events++;
	endtask

	// Inside a window, with its edges drawn often
	function automatic logic [DUR_W-1:0] pick_in(logic [DUR_W-1:0] lo, logic [DUR_W-1:0] hi);
		case ($urandom_range(0, 5))
		0: return lo;
		1: return hi;
		default: return DUR_W'($urandom_range(lo, hi));
		endcase
	endfunction

	// Outside a window, just past its edges or anywhere beyond
	function automatic logic [DUR_W-1:0] pick_out(logic [DUR_W-1:0] lo, logic [DUR_W-1:0] hi);
		case ($urandom_range(0, 3))
		0: return lo - 1'b1;
		1: return hi + 1'b1;
		2: return DUR_W'($urandom_range(0, lo - 1));
		default: return DUR_W'($urandom_range(hi + 1, 16'hffff));
		endcase
	endfunction

	// Frame content: mostly for the programmed remote, sometimes foreign or corrupt
	function automatic logic [FRAME_BITS-1:0] pick_frame();
		logic [FIELD_W-1:0] key, inv_key, c_high, c_low;
		key = FIELD_W'($urandom());
		inv_key = ~key;
		c_high = reg_head[13:8];
		c_low = reg_head[5:0];
		case ($urandom_range(0, 9))
		0: inv_key ^= FIELD_W'($urandom_range(1, 63));
		1: {c_high, c_low} = 12'($urandom());
		default: ;
		endcase
		return {inv_key, c_high, key, c_low};
	endfunction

	// Queue a whole frame, LSB first; break the event at position cut (none if negative).
	task automatic queue_frame(logic [FRAME_BITS-1:0] bits, int cut);
		logic p;
		logic [DUR_W-1:0] d;
		for (int i = 0; i < 2 * FRAME_BITS + 2; i++) begin
			if (i == 0) begin
				p = 1'b1;
				d = pick_in(HDR_PULSE_MIN, HDR_PULSE_MAX);
			end else if (i == 1) begin
				p = 1'b0;
				d = pick_in(HDR_SPACE_MIN, HDR_SPACE_MAX);
			end else if (i % 2 == 0) begin
				p = 1'b1;
				d = pick_in(BIT_PULSE_MIN, BIT_PULSE_MAX);
			end else begin
				p = 1'b0;
				d = bits[(i - 3) / 2] ? pick_in(ONE_SPACE_MIN, ONE_SPACE_MAX)
					: pick_in(ZERO_SPACE_MIN, ZERO_SPACE_MAX);
			end
			if (i == cut) begin
				if ($urandom_range(0, 1))
					p = !p;
				else if (i < 2)
					d = pick_out(HDR_PULSE_MIN, HDR_PULSE_MAX);
				else if (p)
					d = pick_out(BIT_PULSE_MIN, BIT_PULSE_MAX);
				else if ($urandom_range(0, 1))
					d = DUR_W'($urandom_range(ZERO_SPACE_MAX + 1, ONE_SPACE_MIN - 1));
				else
					d = pick_out(ZERO_SPACE_MIN, ONE_SPACE_MAX);
			end
			queue_event(p, d);
		end
	endtask

	// Issue one register write request and mirror it once it lands.
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
		CFG_ENABLE:  reg_enable  = val[0];
		CFG_HEAD:    reg_head    = val[CODE_W-1:0];
		CFG_RSPEED:  reg_rspeed  = val[SPEED_W-1:0];
		CFG_DSPEED:  reg_dspeed  = val[SPEED_W-1:0];
		CFG_TIMEOUT: reg_timeout = val;
		default: ;
		endcase
	endtask

	// Wait until every queued event is sent and every owed report has come back, then let the pipe settle.
	task automatic drain();
		while (ir_events.size() != 0 || ev_bus.valid || owed_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [FRAME_BITS-1:0] last_frame;
		logic                  have_frame;
		int                    budget;

		// Drive every input known from time zero, hold reset
		arst_n = 1'b0;
		ev_bus.valid = 1'b0;
		ev_bus.is_pulse = 1'b0;
		ev_bus.duration = '0;
		ev_bus.now_time = '0;
		rpt_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_ENABLE;
		cfg_bus.data = '0;

		reg_enable = 1'b0;
		reg_head = '0;
		reg_rspeed = '0;
		reg_dspeed = '0;
		reg_timeout = '0;
		dec_phase = PH_IDLE;
		dec_bits = '0;
		dec_shift = '0;
		dec_prev_frame = '0;
		dec_last_key = '0;
		dec_repeats = '0;
		dec_latched = 1'b0;

		t_now = $urandom();
		phase_events = 0;
		fail_count = 0;
		calm = 1'b0;
		src_gap = 0;
		sink_gap = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		have_frame = 1'b0;
		last_frame = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Out of reset the decoder is disabled: a valid header still errors
		queue_event(1'b1, 16'd2500);
		queue_event(1'b0, 16'd2500);
		drain();

		write_reg(CFG_ENABLE, 16'd1);
		write_reg(CFG_HEAD, {2'b00, 6'($urandom()), 2'b00, 6'($urandom())});
		write_reg(CFG_RSPEED, 16'd0);
		write_reg(CFG_DSPEED, 16'd0);
		write_reg(CFG_TIMEOUT, 16'hffff);

		// Directed: window edges, wrong kinds in every phase, a bad bit space
		queue_event(1'b0, 16'd2500);            // space while idle
		queue_event(1'b1, HDR_PULSE_MIN - 1'b1);
		queue_event(1'b1, HDR_PULSE_MAX + 1'b1);
		queue_event(1'b1, 16'd0);
		queue_event(1'b1, 16'hffff);
		queue_event(1'b1, HDR_PULSE_MIN);       // header taken
		queue_event(1'b1, 16'd2500);            // mark where header space belongs
		queue_event(1'b1, HDR_PULSE_MAX);
		queue_event(1'b0, HDR_SPACE_MIN - 1'b1);
		queue_event(1'b1, 16'd2500);
		queue_event(1'b0, HDR_SPACE_MAX);
		queue_event(1'b0, 16'd500);             // space where bit mark belongs
		queue_event(1'b1, 16'd2500);
		queue_event(1'b0, HDR_SPACE_MIN);
		queue_event(1'b1, BIT_PULSE_MIN - 1'b1);
		queue_event(1'b1, 16'd2500);
		queue_event(1'b0, 16'd2500);
		queue_event(1'b1, BIT_PULSE_MIN);
		queue_event(1'b0, ONE_SPACE_MIN);
		queue_event(1'b1, BIT_PULSE_MAX);
		queue_event(1'b0, ZERO_SPACE_MAX);
		queue_event(1'b1, 16'd500);
		queue_event(1'b0, ONE_SPACE_MAX + 1'b1); // bad bit space, shift still advances
		queue_event(1'b1, 16'd2500);
		queue_event(1'b0, 16'd2500);
		queue_event(1'b1, 16'd500);
		queue_event(1'b1, 16'd500);              // mark where bit space belongs
		drain();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			budget = 280;
			case (ph)
			0: ;  // repeats flagged at once, widest timeout
			1: begin
				write_reg(CFG_HEAD, 16'd0);
				write_reg(CFG_RSPEED, 16'd3);
				write_reg(CFG_DSPEED, 16'd255);
			end
			2: begin
				write_reg(CFG_HEAD, {2'b00, 6'($urandom()), 2'b00, 6'($urandom())});
				write_reg(CFG_RSPEED, 16'd255);
				write_reg(CFG_DSPEED, 16'd1);
				write_reg(CFG_TIMEOUT, 16'd300);
				t_now = 32'hffff_ff80;  // wrap the clock mid-phase
			end
			3: begin
				write_reg(CFG_HEAD, 16'h3fff);  // unreachable custom code
				write_reg(CFG_RSPEED, 16'd1);
				write_reg(CFG_DSPEED, 16'd2);
				write_reg(CFG_TIMEOUT, 16'd0);
			end
			4: begin
				write_reg(CFG_ENABLE, 16'd0);
				budget = 100;
			end
			default: begin
				write_reg(CFG_ENABLE, 16'd1);
				write_reg(CFG_HEAD, {2'b00, 6'($urandom()), 2'b00, 6'($urandom())});
				write_reg(CFG_RSPEED, 16'($urandom_range(0, 255)));
				write_reg(CFG_DSPEED, 16'($urandom_range(0, 255)));
				write_reg(CFG_TIMEOUT, 16'($urandom_range(100, 65535)));
				calm = 1'b1;
			end
			endcase

			// ask the receiver for its long stall while events keep coming
			if (ph == 1 || ph == 3)
				hold_req++;

			phase_events = 0;
			while (phase_events < budget) begin
				if ($urandom_range(0, 99) < 15) begin
					// noise: loose marks and spaces of any length
					repeat ($urandom_range(1, 6))
						queue_event(1'($urandom()), $urandom_range(0, 1) ? 16'($urandom())
							: pick_in(ZERO_SPACE_MIN, HDR_SPACE_MAX));
				end else begin
					if (!have_frame || $urandom_range(0, 99) >= 45)
						last_frame = pick_frame();
					have_frame = 1'b1;
					// gap before the frame: mostly short, sometimes around or past the timeout
					case ($urandom_range(0, 9))
					0: t_now += TIME_W'(reg_timeout) + $urandom_range(0, 200);
					1: t_now += $urandom();
					default: t_now += $urandom_range(0, 20);
					endcase
					queue_frame(last_frame,
						($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 49)) : -1);
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && owed_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
src/irpd_pkg.sv
src/irpd_ifs.sv
src/ir_pulse_distance_decoder_core.sv
dv/tb_ir_pulse_distance_decoder_core.sv
